/* hw/rtl/nrbc_pkg.sv */
// Package for the Newton root-basin classifier: widths, constants and codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nrbc_pkg;
	localparam int FRAC_BITS  = 28;
	localparam int MAX_DEGREE = 10;
	localparam int ITER_LIMIT = 1000;
	localparam int COUNT_CAP  = 50;
	localparam int IT_W       = 10;
	localparam int DEG_W      = 4;
	localparam int ROT_W      = 30;
	localparam int ROOT_W     = 32;
	localparam int RIDX_W     = 4;

	localparam logic signed [63:0] SAT_MAG = 64'sh3FFF_FFFF_FFFF_FFFF;
	// 1e-3 rounded to the nearest fraction step
	localparam logic signed [63:0] TOL     = ((64'sd1 << FRAC_BITS) + 64'sd500) / 64'sd1000;
	localparam logic signed [63:0] ESC     = 64'sd10000000000 << FRAC_BITS;

	localparam logic [1:0] REG_DEGREE = 2'd0;
	localparam logic [1:0] REG_COS    = 2'd1;
	localparam logic [1:0] REG_SIN    = 2'd2;

	// shared unit operations
	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_DIV = 2'd1;

	typedef struct packed {
		logic       abort;
		logic       start;
		logic [1:0] op;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} alu_req_t;

	function automatic logic signed [63:0] clampw(input logic signed [65:0] v);
		if (v > 66'(SAT_MAG)) return SAT_MAG;
		if (v < -66'(SAT_MAG)) return -SAT_MAG;
		return v[63:0];
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic in_tol(input logic signed [63:0] v);
		return (v <= TOL) && (v >= -TOL);
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/nrbc_alu.sv */
// Shared multi-cycle arithmetic unit: Q.28 multiply (4 partial products of
// 32x32, one per cycle) and Q.28 restoring divide (one quotient bit a cycle).
// Depends on nrbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nrbc_alu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire nrbc_pkg::alu_req_t req,
	output logic                   done,
	output logic signed [63:0]     result
);
	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_MUL  = 2'd1;
	localparam logic [1:0] A_DIV  = 2'd2;

	logic [1:0]   state_q;
	logic [6:0]   cnt_q;
	logic         neg_q;
	logic [63:0]  ua_q, ub_q;
	logic [127:0] acc_q;
	logic [63:0]  rem_q, lo_q, quo_q;
	logic         done_q;
	logic signed [63:0] res_q;

	logic [63:0] ua, ub, pp, sat;
	logic [31:0] pa, pb;
	logic [64:0] rsh;
	logic [127:0] prod_sh;

	always_comb begin
		ua = req.a[63] ? 64'(-req.a) : req.a;
		ub = req.b[63] ? 64'(-req.b) : req.b;
		pa = cnt_q[0] ? ua_q[63:32] : ua_q[31:0];
		pb = cnt_q[1] ? ub_q[63:32] : ub_q[31:0];
		pp = 64'(pa) * 64'(pb);
		rsh = {rem_q, lo_q[63]};
		prod_sh = acc_q >> nrbc_pkg::FRAC_BITS;
		sat = 64'(nrbc_pkg::SAT_MAG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			// drop any operation in progress
			if (req.abort) begin
				state_q <= A_IDLE;
			end else begin
				unique case (state_q)
					A_IDLE: if (req.start) begin
						neg_q <= (req.op == nrbc_pkg::OP_MUL) ? (req.a[63] ^ req.b[63]) : req.a[63];
						ua_q  <= ua;
						ub_q  <= (req.op == nrbc_pkg::OP_MUL) ? ub : req.b;
						cnt_q <= '0;
						acc_q <= '0;
						rem_q <= 64'(ua >> (64 - nrbc_pkg::FRAC_BITS));
						lo_q  <= ua << nrbc_pkg::FRAC_BITS;
						quo_q <= '0;
						state_q <= (req.op == nrbc_pkg::OP_MUL) ? A_MUL : A_DIV;
					end
					A_MUL: begin
						acc_q <= acc_q + (128'(pp) << (32 * (32'(cnt_q[0]) + 32'(cnt_q[1]))));
						cnt_q <= cnt_q + 7'd1;
						if (cnt_q == 7'd4) begin
							res_q <= (prod_sh[127:64] != 0 || prod_sh[63:0] > sat) ?
								(neg_q ? -nrbc_pkg::SAT_MAG : nrbc_pkg::SAT_MAG) :
								(neg_q ? -$signed(prod_sh[63:0]) : $signed(prod_sh[63:0]));
							done_q  <= 1'b1;
							state_q <= A_IDLE;
						end
					end
					A_DIV: begin
						if (cnt_q == 7'd0 && rem_q >= ub_q) begin
							res_q <= neg_q ? -nrbc_pkg::SAT_MAG : nrbc_pkg::SAT_MAG;
							done_q <= 1'b1;
							state_q <= A_IDLE;
						end else if (cnt_q == 7'd64) begin
							res_q <= (quo_q > sat) ?
								(neg_q ? -nrbc_pkg::SAT_MAG : nrbc_pkg::SAT_MAG) :
								(neg_q ? -$signed(quo_q) : $signed(quo_q));
							done_q <= 1'b1;
							state_q <= A_IDLE;
						end else begin
							// one restoring step
							if (rsh >= 65'(ub_q)) begin
								rem_q <= 64'(rsh - 65'(ub_q));
								quo_q <= {quo_q[62:0], 1'b1};
							end else begin
								rem_q <= rsh[63:0];
								quo_q <= {quo_q[62:0], 1'b0};
							end
							lo_q  <= lo_q << 1;
							cnt_q <= cnt_q + 7'd1;
						end
					end
					default: state_q <= A_IDLE;
				endcase
			end
		end
	end

	// the mul state runs count 0..3 accumulating, 4 finishes; the add on 4 is unused
	assign done   = done_q;
	assign result = res_q;
endmodule
`default_nettype wire

/* hw/rtl/newton_root_basin_classifier_top.sv */
// Newton root-basin classifier for z^d - 1: one point per item, one item at a time.
// Newton step: 4*(d-2) + 2 multiplies, six divides (two by |s|^2, four by d), an
// update and up to d root compares. Up to 1000 steps, then S_OUT and S_WAIT (held
// while a result is pending) to the output register; degree one goes straight to
// S_OUT. Root table rebuilt (4*MAX_DEGREE multiplies) after reset and cfg writes.
// Reset (arst_n, async low): registers to 3/cos/sin defaults, sequencer rebuilds.
`timescale 1ns / 1ps
`default_nettype none
module newton_root_basin_classifier_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [29:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // start_re[31:0], start_im[63:32]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // attractor[3:0], step_count[9:4], zero
);
	localparam logic [4:0] S_RBLD  = 5'd0;
	localparam logic [4:0] S_RWAIT = 5'd1;
	localparam logic [4:0] S_IDLE  = 5'd2;
	localparam logic [4:0] S_PWR   = 5'd3;
	localparam logic [4:0] S_R2    = 5'd4;
	localparam logic [4:0] S_DIV   = 5'd5;
	localparam logic [4:0] S_UPD   = 5'd6;
	localparam logic [4:0] S_CMP   = 5'd7;
	localparam logic [4:0] S_OUT   = 5'd8;
	localparam logic [4:0] S_WAIT  = 5'd9;

	logic [4:0] state_q, ret_q;
	logic [nrbc_pkg::DEG_W-1:0] degree_q;
	logic signed [nrbc_pkg::ROT_W-1:0] cos_q, sin_q;
	logic signed [nrbc_pkg::ROOT_W-1:0] root_re_q [nrbc_pkg::MAX_DEGREE];
	logic signed [nrbc_pkg::ROOT_W-1:0] root_im_q [nrbc_pkg::MAX_DEGREE];
	logic [nrbc_pkg::RIDX_W-1:0] k_q;
	logic [2:0] sub_q;
	logic [nrbc_pkg::IT_W-1:0] it_q;
	logic signed [63:0] zr_q, zi_q, sr_q, si_q, t0_q, t1_q, t2_q, t3_q, r2_q;
	logic signed [63:0] rr_q, ri_q;
	logic [3:0] att_q;
	logic [5:0] cnt_q;
	logic [9:0] out_q;
	logic m_valid_q;
	nrbc_pkg::alu_req_t req;
	logic alu_done;
	logic signed [63:0] alu_res;
	logic [3:0] d;
	logic signed [63:0] dsh;

	nrbc_alu u_alu (.clk(clk), .arst_n(arst_n), .req(req), .done(alu_done), .result(alu_res));

	always_comb begin
		if (degree_q == 4'd0) d = 4'd1;
		else if (degree_q > 4'(nrbc_pkg::MAX_DEGREE)) d = 4'(nrbc_pkg::MAX_DEGREE);
		else d = degree_q;
		// d in the same fraction format, so the shared divide gives x / d
		dsh = 64'(d) << nrbc_pkg::FRAC_BITS;
	end

	// operand selection for the shared unit
	logic signed [63:0] op_a, op_b;
	logic [1:0] op_c;
	logic op_go;
	always_comb begin
		op_a = zr_q; op_b = sr_q; op_c = nrbc_pkg::OP_MUL; op_go = 1'b0;
		unique case (state_q)
			S_RBLD: begin
				op_go = 1'b1;
				unique case (sub_q[1:0])
					2'd0: begin op_a = rr_q; op_b = 64'(cos_q); end
					2'd1: begin op_a = ri_q; op_b = 64'(sin_q); end
					2'd2: begin op_a = rr_q; op_b = 64'(sin_q); end
					default: begin op_a = ri_q; op_b = 64'(cos_q); end
				endcase
			end
			S_PWR: begin
				op_go = 1'b1;
				unique case (sub_q[1:0])
					2'd0: begin op_a = zr_q; op_b = sr_q; end
					2'd1: begin op_a = zi_q; op_b = si_q; end
					2'd2: begin op_a = zi_q; op_b = sr_q; end
					default: begin op_a = zr_q; op_b = si_q; end
				endcase
			end
			S_R2: begin
				op_go = 1'b1;
				op_a = sub_q[0] ? si_q : sr_q;
				op_b = op_a;
			end
			S_DIV: begin
				op_go = 1'b1; op_c = nrbc_pkg::OP_DIV;
				op_b = (sub_q < 3'd2) ? r2_q : dsh;
				unique case (sub_q)
					3'd0: op_a = sr_q;
					3'd1: op_a = si_q;
					3'd2: op_a = t0_q;
					3'd3: op_a = t1_q;
					3'd4: op_a = zr_q;
					default: op_a = zi_q;
				endcase
			end
			default: ;
		endcase
		req.abort = cfg_we;
		req.start = op_go && !cfg_we;
		req.op = op_c;
		req.a = op_a;
		req.b = op_b;
	end

	logic signed [63:0] nzr, nzi;
	logic signed [63:0] cr, ci;
	always_comb begin
		nzr = nrbc_pkg::clampw(66'(nrbc_pkg::clampw(66'(zr_q) - 66'(t2_q))) + 66'(t0_q));
		nzi = nrbc_pkg::clampw(66'(nrbc_pkg::clampw(66'(zi_q) - 66'(t3_q))) - 66'(t1_q));
		cr = zr_q - 64'(root_re_q[k_q]);
		ci = zi_q - 64'(root_im_q[k_q]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_RBLD;
			ret_q     <= S_IDLE;
			sub_q     <= '0;
			k_q       <= '0;
			degree_q  <= 4'd3;
			cos_q     <= -30'sd134217728;
			sin_q     <= 30'sd232471925;
			rr_q      <= 64'sd268435456;
			ri_q      <= '0;
			out_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready) m_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					nrbc_pkg::REG_DEGREE: degree_q <= cfg_wdata[3:0];
					nrbc_pkg::REG_COS:    cos_q <= cfg_wdata;
					nrbc_pkg::REG_SIN:    sin_q <= cfg_wdata;
					default: ;
				endcase
				if (cfg_index == nrbc_pkg::REG_DEGREE || cfg_index == nrbc_pkg::REG_COS
					|| cfg_index == nrbc_pkg::REG_SIN) begin
					state_q <= S_RBLD; sub_q <= '0; k_q <= '0;
					rr_q <= 64'sd268435456; ri_q <= '0;
				end
			end else begin
				unique case (state_q)
					S_RBLD: begin
						if (sub_q == 3'd0) begin
							root_re_q[k_q] <= rr_q[31:0];
							root_im_q[k_q] <= ri_q[31:0];
						end
						ret_q <= S_RBLD; state_q <= S_RWAIT;
					end
					S_PWR, S_R2, S_DIV: begin ret_q <= state_q; state_q <= S_RWAIT; end
					S_RWAIT: if (alu_done) begin
						unique case (ret_q)
							S_RBLD: begin
								// root products truncate with >>28 toward zero
								unique case (sub_q[1:0])
									2'd0: t0_q <= alu_res;
									2'd1: t1_q <= alu_res;
									2'd2: t2_q <= alu_res;
									default: t3_q <= alu_res;
								endcase
								if (sub_q == 3'd3) begin
									rr_q <= 64'(nrbc_pkg::clamp32(t0_q - t1_q));
									ri_q <= 64'(nrbc_pkg::clamp32(t2_q + alu_res));
									sub_q <= '0;
									if (k_q == 4'(nrbc_pkg::MAX_DEGREE - 1)) state_q <= S_IDLE;
									else begin k_q <= k_q + 4'd1; state_q <= S_RBLD; end
								end else begin
									sub_q <= sub_q + 3'd1; state_q <= S_RBLD;
								end
							end
							S_PWR: begin
								unique case (sub_q[1:0])
									2'd0: t0_q <= alu_res;
									2'd1: t1_q <= alu_res;
									2'd2: t2_q <= alu_res;
									default: t3_q <= alu_res;
								endcase
								if (sub_q == 3'd3) begin
									sr_q <= nrbc_pkg::clampw(66'(t0_q) - 66'(t1_q));
									si_q <= nrbc_pkg::clampw(66'(t2_q) + 66'(alu_res));
									sub_q <= '0;
									k_q <= k_q + 4'd1;
									state_q <= (k_q + 4'd1 >= d - 4'd2) ? S_R2 : S_PWR;
								end else begin
									sub_q <= sub_q + 3'd1; state_q <= S_PWR;
								end
							end
							S_R2: begin
								if (sub_q == 3'd0) begin
									t0_q <= alu_res; sub_q <= 3'd1; state_q <= S_R2;
								end else begin
									r2_q <= nrbc_pkg::clampw(66'(t0_q) + 66'(alu_res));
									sub_q <= '0;
									if (nrbc_pkg::clampw(66'(t0_q) + 66'(alu_res)) == 64'sd0) begin
										att_q <= '0;
										cnt_q <= (it_q > 10'(nrbc_pkg::COUNT_CAP)) ?
											6'(nrbc_pkg::COUNT_CAP) : 6'(it_q);
										state_q <= S_OUT;
									end else state_q <= S_DIV;
								end
							end
							default: begin
								// s/|s|^2 parts, then their quotients by d, then z by d
								unique case (sub_q)
									3'd0, 3'd2: t0_q <= alu_res;
									3'd1, 3'd3: t1_q <= alu_res;
									3'd4: t2_q <= alu_res;
									default: t3_q <= alu_res;
								endcase
								if (sub_q == 3'd5) begin
									sub_q <= '0; state_q <= S_UPD;
								end else begin
									sub_q <= sub_q + 3'd1; state_q <= S_DIV;
								end
							end
						endcase
					end
					S_IDLE: if (s_tvalid && s_tready) begin
						zr_q <= 64'($signed(s_tdata[31:0]));
						zi_q <= 64'($signed(s_tdata[63:32]));
						it_q <= '0;
						if (d == 4'd1) begin
							att_q <= 4'd1; cnt_q <= '0; state_q <= S_OUT;
						end else begin
							sr_q <= 64'($signed(s_tdata[31:0]));
							si_q <= 64'($signed(s_tdata[63:32]));
							k_q <= '0; sub_q <= '0;
							state_q <= (d == 4'd2) ? S_R2 : S_PWR;
						end
					end
					S_UPD: begin
						zr_q <= nzr; zi_q <= nzi; k_q <= '0;
						state_q <= S_CMP;
					end
					S_CMP: begin
						// origin, escape, then roots in order
						if (nrbc_pkg::in_tol(zr_q) && nrbc_pkg::in_tol(zi_q)
							|| zr_q >= nrbc_pkg::ESC || zr_q <= -nrbc_pkg::ESC
							|| zi_q >= nrbc_pkg::ESC || zi_q <= -nrbc_pkg::ESC) begin
							att_q <= '0;
							cnt_q <= (it_q > 10'(nrbc_pkg::COUNT_CAP)) ?
								6'(nrbc_pkg::COUNT_CAP) : 6'(it_q);
							state_q <= S_OUT;
						end else if (nrbc_pkg::in_tol(cr) && nrbc_pkg::in_tol(ci)) begin
							att_q <= k_q + 4'd1;
							cnt_q <= (it_q > 10'(nrbc_pkg::COUNT_CAP)) ?
								6'(nrbc_pkg::COUNT_CAP) : 6'(it_q);
							state_q <= S_OUT;
						end else if (k_q != d - 4'd1) begin
							k_q <= k_q + 4'd1;
						end else if (it_q == 10'(nrbc_pkg::ITER_LIMIT - 1)) begin
							att_q <= '0; cnt_q <= 6'(nrbc_pkg::COUNT_CAP); state_q <= S_OUT;
						end else begin
							it_q <= it_q + 10'd1;
							sr_q <= zr_q; si_q <= zi_q; k_q <= '0; sub_q <= '0;
							state_q <= (d == 4'd2) ? S_R2 : S_PWR;
						end
					end
					S_OUT: begin
						if (cnt_q > 6'(nrbc_pkg::COUNT_CAP)) cnt_q <= 6'(nrbc_pkg::COUNT_CAP);
						state_q <= S_WAIT;
					end
					S_WAIT: if (!m_valid_q) begin
						out_q <= {cnt_q, att_q};
						m_valid_q <= 1'b1; state_q <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign s_tready = (state_q == S_IDLE) && !cfg_we;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, out_q};

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:4] <= 6'(nrbc_pkg::COUNT_CAP))) else $error("count over cap");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed while held");
endmodule
`default_nettype wire
